// ----- sv/assert_macros.svh -----
// Assertion macros shared by the bitmap region counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/brbc_pkg.sv -----
// Shared types, mode codes and popcount helper for the bitmap region counter.
package brbc_pkg;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_PIXEL = 3'd1;
	localparam logic [2:0] MODE_ROW   = 3'd2;
	localparam logic [2:0] MODE_COL   = 3'd3;
	localparam logic [2:0] MODE_RECT  = 3'd4;

	localparam logic [16:0] COUNT_MAX = 17'd65536;

	typedef struct packed {
		logic wr;       // store a bitmap byte from the input transfer
		logic load;     // latch query fields from the input transfer
		logic setup;    // range check and loop setup
		logic step;     // issue one bitmap read
		logic finish;   // move the count into the result register
	} dp_cmd_t;

	typedef struct packed {
		logic skip;     // nothing to read: out of range or zero extent
		logic last;     // the read issued now is the final one
		logic rd_pend;  // a read is still on its way to the accumulator
	} dp_sts_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		a = v - ((v >> 1) & 8'h55);
		b = (a & 8'h33) + ((a >> 2) & 8'h33);
		c = (b + (b >> 4)) & 8'h0F;
		return c[3:0];
	endfunction

endpackage

// ----- sv/brbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/brbc_ctrl.sv -----
// Controller state machine: sequences writes, query setup, reads and result handoff.
`include "assert_macros.svh"

module brbc_ctrl import brbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic [2:0] mode,
	output logic      m_tvalid,
	input  logic      m_tready,
	output dp_cmd_t   cmd,
	input  dp_sts_t   sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;
	logic       accept;
	logic       is_query;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_query = mode inside {MODE_PIXEL, MODE_ROW, MODE_COL, MODE_RECT};
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.wr     = accept && (mode == MODE_WRITE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				if (sts.skip) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold the count until the result register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMPLIES(a_finish_drained, clk, arst_n, cmd.finish, !sts.rd_pend, "result taken with a read in flight")
	`ASSERT_IMPLIES(a_tvalid_after_fin, clk, arst_n, $rose(m_tvalid), $past(state_q) == ST_FIN, "result raised outside the finish step")

endmodule

// ----- sv/brbc_dp.sv -----
// Datapath: range check, read address walk, bitmap store, masked popcount and result.
`include "assert_macros.svh"

module brbc_dp import brbc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT,
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [8:0]  row_pixels,
	input  logic [2:0]  mode,
	input  logic [12:0] load_addr,
	input  logic [7:0]  load_data,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [8:0]  span_width,
	input  logic [8:0]  span_height,
	output logic [16:0] blocked_count,
	output logic        out_of_range
);

	localparam int MAXW_FLOOR = MAX_WIDTH - (MAX_WIDTH % 8);
	localparam logic [8:0] IW_SAT = 9'((MAXW_FLOOR > 504) ? 504 : MAXW_FLOOR);
	localparam int HCW = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;

	// latched query
	logic [2:0]  mode_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [8:0]  w_q;
	logic [8:0]  h_q;

	// loop state
	logic          bad_q;
	logic          skip_q;
	logic [5:0]    b0_q;
	logic [5:0]    b1_q;
	logic [2:0]    xlo_q;
	logic [2:0]    xhi_q;
	logic [8:0]    rows_q;
	logic [5:0]    cur_b_q;
	logic [5:0]    rb_q;
	logic [AW-1:0] row_base_q;

	logic          rd_vld_s1;
	logic [7:0]    mask_s1;
	logic [16:0]   acc_q;
	logic [16:0]   count_q;
	logic          oor_q;

	logic [8:0]    rp_floor;
	logic [8:0]    iw;
	logic [5:0]    rb;
	logic [8:0]    ext_w;
	logic [8:0]    ext_h;
	logic [9:0]    xw;
	logic [9:0]    last;
	logic [HCW-1:0] yh;
	logic          bad;
	logic [13:0]   base_full;
	logic [AW:0]   rd_sum;
	logic [AW-1:0] rd_addr;
	logic [7:0]    mask;
	logic [7:0]    rdata;
	logic          we;

	always_comb begin
		rp_floor = {row_pixels[8:3], 3'b000};
		if (int'(rp_floor) > MAXW_FLOOR) begin
			iw = IW_SAT;
		end else begin
			iw = rp_floor;
		end
		rb    = iw[8:3];
		ext_w = (mode_q == MODE_ROW || mode_q == MODE_RECT) ? w_q : 9'd1;
		ext_h = (mode_q == MODE_COL || mode_q == MODE_RECT) ? h_q : 9'd1;
		xw    = {2'b00, x_q} + {1'b0, ext_w};
		last  = xw - 10'd1;
		yh    = HCW'(y_q) + HCW'(ext_h);
		bad   = ({1'b0, x_q} >= iw) || (HCW'(y_q) >= HCW'(MAX_HEIGHT)) ||
			(xw > {1'b0, iw}) || (yh > HCW'(MAX_HEIGHT));
		base_full = {6'b000000, y_q} * {8'h00, rb};
	end

	always_comb begin
		rd_sum  = {1'b0, row_base_q} + (AW+1)'(cur_b_q);
		rd_addr = rd_sum[AW-1:0];
		mask    = 8'hFF;
		if (cur_b_q == b0_q) begin
			mask = mask & (8'hFF << xlo_q);
		end
		if (cur_b_q == b1_q) begin
			mask = mask & (8'hFF >> (3'd7 - xhi_q));
		end
	end

	assign sts.skip    = skip_q;
	assign sts.last    = (cur_b_q == b1_q) && (rows_q == 9'd1);
	assign sts.rd_pend = rd_vld_s1;

	// drop writes past the end of the store
	assign we = cmd.wr && (int'(load_addr) < STORE_BYTES);

	brbc_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(load_addr)),
		.wdata (load_data),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			x_q    <= start_x;
			y_q    <= start_y;
			w_q    <= span_width;
			h_q    <= span_height;
		end
		if (cmd.setup) begin
			bad_q      <= bad;
			skip_q     <= bad || (ext_w == 9'd0) || (ext_h == 9'd0);
			b0_q       <= {1'b0, x_q[7:3]};
			b1_q       <= last[8:3];
			xlo_q      <= x_q[2:0];
			xhi_q      <= last[2:0];
			rows_q     <= ext_h;
			cur_b_q    <= {1'b0, x_q[7:3]};
			rb_q       <= rb;
			row_base_q <= AW'(base_full);
		end else if (cmd.step) begin
			// wrap to the first byte of the next row at the end of a span
			if (cur_b_q == b1_q) begin
				cur_b_q    <= b0_q;
				row_base_q <= row_base_q + AW'(rb_q);
				rows_q     <= rows_q - 9'd1;
			end else begin
				cur_b_q <= cur_b_q + 6'd1;
			end
		end
		mask_s1 <= mask;
		if (cmd.finish) begin
			count_q <= acc_q;
			oor_q   <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			acc_q     <= '0;
		end else begin
			rd_vld_s1 <= cmd.step;
			if (cmd.setup) begin
				acc_q <= '0;
			end else if (rd_vld_s1) begin
				acc_q <= acc_q + 17'(pop8(rdata & mask_s1));
			end
		end
	end

	assign blocked_count = count_q;
	assign out_of_range  = oor_q;

	`ASSERT_IMPLIES(a_read_in_store, clk, arst_n, cmd.step, int'(rd_sum) < STORE_BYTES, "read address past the bitmap store")
	`ASSERT_ALWAYS(a_acc_bound, clk, arst_n, acc_q <= COUNT_MAX, "count exceeds the largest region")

endmodule

// ----- sv/bitmap_region_blocked_counter.sv -----
// Top level of the bitmap region counter: width register, controller and datapath.
// A byte write is stored in the cycle it is accepted. A query reads every byte that its region
// touches in each row, one bitmap read a cycle on the single RAM read port; out-of-range and
// empty queries read nothing.
// Throughput: one write per cycle while no query is in progress; a query holds off every
// transfer until its count moves into the result register, but a waiting result does not
// block the next transfer. Reset clears control and sets the width to 256; bitmap contents are undefined until written.
module bitmap_region_blocked_counter import brbc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// load_addr[12:0], load_data[20:13], start_x[28:21], start_y[36:29],
	// span_width[45:37], span_height[54:46], zero [55]
	input  logic [55:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// blocked_count[16:0], zero [23:17]
	output logic [23:0] m_tdata,
	// out_of_range[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);

	logic [8:0]  row_pixels_q;
	logic [16:0] blocked_count;
	logic        out_of_range;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= 9'd256;
		end else if (cfg_we) begin
			row_pixels_q <= cfg_wdata;
		end
	end

	brbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	brbc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.row_pixels    (row_pixels_q),
		.mode          (s_tuser),
		.load_addr     (s_tdata[12:0]),
		.load_data     (s_tdata[20:13]),
		.start_x       (s_tdata[28:21]),
		.start_y       (s_tdata[36:29]),
		.span_width    (s_tdata[45:37]),
		.span_height   (s_tdata[54:46]),
		.blocked_count (blocked_count),
		.out_of_range  (out_of_range)
	);

	assign m_tdata = {7'd0, blocked_count};
	assign m_tuser = out_of_range;

endmodule

// ----- test/tb_top.sv -----
// Testbench for the bitmap region counter: bitmap loads, region count queries, width settings.
`timescale 1ns / 100ps

module tb_top;
	import brbc_pkg::*;

	localparam int IMG_COLS_MAX  = 256;
	localparam int IMG_ROWS      = 256;
	localparam int STORE_DEPTH   = 8192;
	localparam int LOAD_BYTES    = 256;
	localparam int LOAD_ROWS     = LOAD_BYTES / (IMG_COLS_MAX / 8);
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 40000;
	localparam int CHUNK_OPS     = 50;
	localparam logic [2:0] MODE_RSVD_LO = 3'd5;
	localparam logic [2:0] MODE_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [12:0] load_addr;
		logic [7:0]  load_data;
		logic [7:0]  start_x;
		logic [7:0]  start_y;
		logic [8:0]  span_width;
		logic [8:0]  span_height;
	} bitmap_op_t;

	typedef struct packed {
		logic [16:0] blocked_count;
		logic        out_of_range;
	} region_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// load_addr[12:0], load_data[20:13], start_x[28:21], start_y[36:29],
	// span_width[45:37], span_height[54:46], zero [55]
	logic [55:0] s_tdata = '0;
	// mode[2:0]
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// blocked_count[16:0], zero [23:17]
	logic [23:0] m_tdata;
	// out_of_range[0]
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;

	// predictor state
	logic [7:0]     occupancy [STORE_DEPTH];
	logic [8:0]     width_reg = 9'd256;
	region_result_t pending_counts [$];
	region_result_t due;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  err_count = 0;
	int  n_writes = 0;
	int  n_queries = 0;
	int  n_ignored = 0;
	int  n_results = 0;
	int  n_widths = 0;
	int  stall_cycles = 0;
	int  hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;

	bitmap_region_blocked_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_width(input logic [8:0] reg_val);
		int w;
		w = int'(reg_val & 9'h1F8);
		if (w > IMG_COLS_MAX)
			w = IMG_COLS_MAX;
		return w;
	endfunction

	// Rows whose bytes all lie in the loaded part of the store at this width.
	function automatic int loaded_rows(input int iw);
		int rb;
		rb = iw / 8;
		if (rb == 0)
			return IMG_ROWS;
		return (LOAD_BYTES / rb < IMG_ROWS) ? LOAD_BYTES / rb : IMG_ROWS;
	endfunction

	// Count set pixels of the queried region, one pixel at a time.
	function automatic region_result_t predict_region(input bitmap_op_t op);
		region_result_t res;
		int iw, rb, ew, eh, x, y, tot, px, r, c;
		iw = eff_width(width_reg);
		rb = iw / 8;
		x = op.start_x;
		y = op.start_y;
		ew = (op.mode == MODE_ROW || op.mode == MODE_RECT) ? int'(op.span_width) : 1;
		eh = (op.mode == MODE_COL || op.mode == MODE_RECT) ? int'(op.span_height) : 1;
		res.out_of_range = (x >= iw) || (y >= IMG_ROWS) || (x + ew > iw) || (y + eh > IMG_ROWS);
		tot = 0;
		if (!res.out_of_range) begin
			for (r = 0; r < eh; r++) begin
				for (c = 0; c < ew; c++) begin
					px = x + c;
					tot += occupancy[(y + r) * rb + px / 8][px % 8];
				end
			end
		end
		res.blocked_count = tot[16:0];
		return res;
	endfunction

	function automatic bitmap_op_t random_op();
		bitmap_op_t op;
		int iw, rows, pick, x, y, wmax, hmax, ew, eh;
		iw = eff_width(width_reg);
		rows = loaded_rows(iw);
		pick = $urandom_range(99);
		op.load_addr = 13'($urandom);
		op.load_data = 8'($urandom);
		op.start_x = 8'($urandom);
		op.start_y = 8'($urandom);
		op.span_width = 9'($urandom_range(511));
		op.span_height = 9'($urandom_range(511));
		if (pick < 28)
			op.mode = MODE_WRITE;
		else if (pick < 40)
			op.mode = MODE_PIXEL;
		else if (pick < 54)
			op.mode = MODE_ROW;
		else if (pick < 68)
			op.mode = MODE_COL;
		else if (pick < 96)
			op.mode = MODE_RECT;
		else
			op.mode = 3'($urandom_range(MODE_RSVD_HI, MODE_RSVD_LO));
		// keep most queries inside the image, with small regions for most rectangles
		if (op.mode != MODE_WRITE && op.mode <= MODE_RECT && iw > 0 &&
				$urandom_range(9) != 0) begin
			x = $urandom_range(iw - 1);
			y = $urandom_range(rows - 1);
			wmax = iw - x;
			hmax = rows - y;
			op.start_x = 8'(x);
			op.start_y = 8'(y);
			if (op.mode == MODE_RECT && $urandom_range(99) != 0) begin
				op.span_width = 9'($urandom_range((wmax < 48) ? wmax : 48));
				op.span_height = 9'($urandom_range((hmax < 12) ? hmax : 12));
			end else begin
				op.span_width = 9'($urandom_range(wmax));
				op.span_height = 9'($urandom_range(hmax));
			end
			pick = $urandom_range(19);
			if (pick == 0)
				op.span_width = 9'(wmax);
			else if (pick == 1)
				op.span_height = 9'(hmax);
			else if (pick == 2)
				op.span_width = 9'(wmax + 1);
			else if (pick == 3)
				op.span_height = 9'(hmax + 1);
		end
		// move in-range queries that reach below the loaded rows up to the top
		if (op.mode != MODE_WRITE && op.mode <= MODE_RECT) begin
			x = op.start_x;
			y = op.start_y;
			ew = (op.mode == MODE_ROW || op.mode == MODE_RECT) ? int'(op.span_width) : 1;
			eh = (op.mode == MODE_COL || op.mode == MODE_RECT) ? int'(op.span_height) : 1;
			if (x < iw && x + ew <= iw && y + eh <= IMG_ROWS && y + eh > rows) begin
				op.start_y = '0;
				if (eh > rows)
					op.span_height = 9'(rows);
			end
		end
		return op;
	endfunction

	// Offer one item, hold it until the transfer, then update the predictor.
	task automatic send_op(input bitmap_op_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op.mode;
		s_tdata <= {1'b0, op.span_height, op.span_width, op.start_y, op.start_x,
			op.load_data, op.load_addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op.mode == MODE_WRITE) begin
			occupancy[op.load_addr] = op.load_data;
			n_writes++;
		end else if (op.mode <= MODE_RECT) begin
			pending_counts.push_back(predict_region(op));
			n_queries++;
		end else begin
			n_ignored++;
		end
	endtask

	task automatic send_write(input int addr, input int data);
		bitmap_op_t op;
		op = random_op();
		op.mode = MODE_WRITE;
		op.load_addr = 13'(addr);
		op.load_data = 8'(data);
		send_op(op);
	endtask

	task automatic send_query(input logic [2:0] mode, input int x, input int y,
			input int w, input int h);
		bitmap_op_t op;
		op.mode = mode;
		op.load_addr = 13'($urandom);
		op.load_data = 8'($urandom);
		op.start_x = 8'(x);
		op.start_y = 8'(y);
		op.span_width = 9'(w);
		op.span_height = 9'(h);
		send_op(op);
	endtask

	// Drop valid, drain all results, then let a trailing write settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic [8:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = value;
		n_widths++;
	endtask

	task automatic load_bitmap(input bit all_set);
		int a;
		for (a = 0; a < LOAD_BYTES; a++)
			send_write(a, all_set ? 255 : int'($urandom_range(255)));
	endtask

	task automatic test_loaded_band_count();
		load_bitmap(1'b1);
		send_query(MODE_RECT, 0, 0, IMG_COLS_MAX, LOAD_ROWS);
		send_query(MODE_COL, 255, 0, 1, LOAD_ROWS);
		load_bitmap(1'b0);
	endtask

	task automatic test_spans_and_pixels();
		send_query(MODE_PIXEL, 0, 0, 0, 0);
		send_query(MODE_PIXEL, 255, LOAD_ROWS - 1, 511, 511);
		send_query(MODE_ROW, 0, 0, 256, 0);
		// span inside a single byte
		send_query(MODE_ROW, 3, 7, 4, 9);
		send_query(MODE_ROW, 5, 6, 12, 1);
		send_query(MODE_ROW, 255, LOAD_ROWS - 1, 1, 1);
		send_query(MODE_COL, 7, 0, 3, LOAD_ROWS);
		send_query(MODE_COL, 200, LOAD_ROWS - 1, 0, 1);
		send_query(MODE_RECT, 9, 3, 17, 5);
		send_query(MODE_RECT, 0, 0, 8, 1);
		send_write(8191, 8'h80);
		send_query(MODE_PIXEL, 255, 255, 0, 0);
		send_write(8191, 8'h7F);
		send_query(MODE_PIXEL, 255, 255, 0, 0);
	endtask

	task automatic test_empty_extents();
		send_query(MODE_ROW, 17, 4, 0, 6);
		send_query(MODE_COL, 17, 4, 6, 0);
		send_query(MODE_RECT, 10, 10, 0, 5);
		send_query(MODE_RECT, 10, 10, 5, 0);
		send_query(MODE_RECT, 255, 255, 0, 0);
	endtask

	task automatic test_out_of_range();
		send_query(MODE_ROW, 250, 0, 7, 1);
		send_query(MODE_COL, 0, 200, 1, 57);
		send_query(MODE_RECT, 0, 0, 511, 511);
		send_query(MODE_RECT, 0, 0, 257, 1);
		send_query(MODE_RECT, 128, 128, 128, 129);
	endtask

	task automatic test_ignored_modes();
		bitmap_op_t op;
		logic [2:0] m;
		for (m = MODE_RSVD_LO; m != 3'd0; m++) begin
			op = random_op();
			op.mode = m;
			send_op(op);
		end
		send_query(MODE_PIXEL, 1, 1, 0, 0);
	endtask

	task automatic test_width_settings();
		logic [8:0] widths [6];
		int i, k, iw, rows;
		widths = '{9'd8, 9'd0, 9'd13, 9'd100, 9'd511, 9'd256};
		for (i = 0; i < 6; i++) begin
			set_width(widths[i]);
			iw = eff_width(width_reg);
			rows = loaded_rows(iw);
			send_query(MODE_PIXEL, (iw == 0) ? 0 : iw - 1, rows - 1, 0, 0);
			send_query(MODE_PIXEL, (iw >= IMG_COLS_MAX) ? 255 : iw, 0, 0, 0);
			send_query(MODE_ROW, 0, LOAD_ROWS - 1, iw, 0);
			send_query(MODE_ROW, 0, LOAD_ROWS - 1, iw + 1, 0);
			send_query(MODE_RECT, 0, rows - 6, iw, 6);
			for (k = 0; k < 15; k++)
				send_op(random_op());
		end
	endtask

	task automatic test_backpressure();
		int k;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_idle();
		hold_req <= ~hold_req;
		for (k = 0; k < 40; k++)
			send_query((k % 2) ? MODE_PIXEL : MODE_ROW, k, k % LOAD_ROWS, k % 9, 1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int phase, chunk, k;
		logic [8:0] w;
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
			recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 36 : 0;
			for (chunk = 0; chunk < 3; chunk++) begin
				case ($urandom_range(5))
					0, 1: w = 9'd256;
					2: w = 9'd64;
					3: w = 9'd136;
					4: w = 9'd8;
					default: w = 9'($urandom_range(511));
				endcase
				set_width((phase == 0 && chunk == 0) ? 9'd256 : w);
				for (k = 0; k < CHUNK_OPS; k++)
					send_op(random_op());
			end
		end
	endtask

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_counts.size() == 0) begin
				$error("unexpected result: blocked_count %0d out_of_range %0d",
					m_tdata[16:0], m_tuser[0]);
				err_count++;
			end else begin
				due = pending_counts.pop_front();
				if (m_tdata[16:0] !== due.blocked_count) begin
					$error("blocked_count: expected %0d, got %0d",
						due.blocked_count, m_tdata[16:0]);
					err_count++;
				end
				if (m_tuser[0] !== due.out_of_range) begin
					$error("out_of_range: expected %0d, got %0d",
						due.out_of_range, m_tuser[0]);
					err_count++;
				end
			end
		end
	end

	// watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_counts.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 36;
		recv_idle_pct = 55;
		test_loaded_band_count();
		test_spans_and_pixels();
		test_empty_extents();
		test_out_of_range();
		test_ignored_modes();
		test_width_settings();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		repeat (16) @(posedge clk);
		$display("covered %0d byte writes, %0d queries and %0d ignored items", n_writes,
			n_queries, n_ignored);
		$display("checked %0d results over %0d width settings, %0d errors", n_results,
			n_widths, err_count);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
